// ===== src/rtf_pkg.sv =====
package rtf_pkg;

    localparam int MAX_NEST = 255;
    localparam int DEPTH_W  = $clog2(MAX_NEST + 1);

    // result items per input item, and the queue that absorbs them
    localparam int MAX_RES     = 3;
    localparam int RES_CNT_W   = 2;
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_PTR_W  = 2;
    localparam int FIFO_CNT_W  = 3;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h27;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_LBR   = 8'h7B;
    localparam logic [7:0] CH_RBR   = 8'h7D;

    localparam logic [23:0] WORD_TAB = 24'h746162;
    localparam logic [23:0] WORD_PAR = 24'h706172;

    typedef enum logic [2:0] {
        MODE_NORMAL,
        MODE_ESC,
        MODE_WORD,
        MODE_HEX_FIRST,
        MODE_HEX_SECOND,
        MODE_SKIP,
        MODE_SKIP_ESC
    } mode_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       last;
    } item_t;

    typedef struct packed {
        logic [RES_CNT_W-1:0]      cnt;
        item_t [MAX_RES-1:0]       item;
    } res_t;

    typedef struct packed {
        logic [FIFO_CNT_W-1:0] fill;
    } fifo_stat_t;

endpackage

// ===== src/rtf_if.sv =====
interface rtf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_text;

    modport source (output valid, output in_byte, output end_of_text, input ready);
    modport sink (input valid, input in_byte, input end_of_text, output ready);
endinterface

interface rtf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       has_byte;
    logic       last;

    modport source (output valid, output out_byte, output has_byte, output last, input ready);
    modport sink (input valid, input out_byte, input has_byte, input last, output ready);
endinterface

// ===== src/rtf_parser.sv =====
module rtf_parser
    import rtf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] in_byte,
    input  logic       eot,
    output res_t       res
);

    typedef struct packed {
        mode_t              mode;
        logic [DEPTH_W-1:0] gdepth;
        logic [DEPTH_W-1:0] sdepth;
        logic [23:0]        letters;
        logic [2:0]         wlen;
        logic [7:0]         hex;
        logic               hex_stop;
    } pstate_t;

    localparam pstate_t ST_RESET = '{MODE_NORMAL, '0, '0, '0, '0, '0, 1'b0};
    localparam logic [DEPTH_W-1:0] DEPTH_MAX = DEPTH_W'(MAX_NEST);
    localparam logic [DEPTH_W-1:0] DEPTH_ONE = DEPTH_W'(1);

    pstate_t st_reg;
    pstate_t st_next;

    logic               is_delim;
    logic [7:0]         low_byte;
    logic               hex_ok;
    logic [3:0]         hex_d;
    logic [7:0]         hex_upd;
    logic               stop_upd;
    logic               word_tab;
    logic               word_par;
    mode_t              nb_mode;
    logic [DEPTH_W-1:0] nb_g;
    logic [DEPTH_W-1:0] nb_s;
    logic [DEPTH_W-1:0] skip_dec;

    function automatic item_t mk(input logic [7:0] b, input logic has, input logic lst);
        item_t it;
        it.out_byte = b;
        it.has_byte = has;
        it.last     = lst;
        return it;
    endfunction

    assign is_delim = in_byte inside {CH_BSL, CH_LBR, CH_RBR, CH_CR, CH_LF, CH_SP};
    assign low_byte = (in_byte inside {[8'h41:8'h5A]}) ? in_byte + 8'd32 : in_byte;
    assign word_tab = (st_reg.wlen == 3'd3) && (st_reg.letters == WORD_TAB);
    assign word_par = (st_reg.wlen == 3'd3) && (st_reg.letters == WORD_PAR);
    assign skip_dec = (st_reg.sdepth != '0) ? st_reg.sdepth - DEPTH_ONE : st_reg.sdepth;

    always_comb
    begin
        hex_ok = 1'b1;
        hex_d  = 4'd0;
        case (in_byte) inside
            [8'h30:8'h39]: hex_d = in_byte[3:0];
            [8'h41:8'h46],
            [8'h61:8'h66]: hex_d = in_byte[3:0] + 4'd9;
            default:       hex_ok = 1'b0;
        endcase
    end

    // digits stop at the first non-hex byte
    assign hex_upd  = (!st_reg.hex_stop && hex_ok) ? {st_reg.hex[3:0], hex_d} : st_reg.hex;
    assign stop_upd = st_reg.hex_stop | ~hex_ok;

    // effect of a byte seen in plain text
    always_comb
    begin
        nb_mode = MODE_NORMAL;
        nb_g    = st_reg.gdepth;
        nb_s    = st_reg.sdepth;
        case (in_byte)
            CH_LBR:
            begin
                if (st_reg.gdepth != '0)
                begin
                    nb_s    = DEPTH_ONE;
                    nb_mode = MODE_SKIP;
                end
                else if (st_reg.gdepth < DEPTH_MAX)
                begin
                    nb_g = st_reg.gdepth + DEPTH_ONE;
                end
            end
            CH_RBR:
            begin
                if (st_reg.gdepth != '0)
                begin
                    nb_g = st_reg.gdepth - DEPTH_ONE;
                end
            end
            CH_BSL:  nb_mode = MODE_ESC;
            default: nb_mode = MODE_NORMAL;
        endcase
    end

    // next state
    always_comb
    begin
        st_next = st_reg;
        if (eot)
        begin
            st_next = ST_RESET;
        end
        else
        begin
            case (st_reg.mode)
                MODE_ESC:
                begin
                    if (in_byte inside {CH_BSL, CH_LBR, CH_RBR})
                    begin
                        st_next.mode = MODE_NORMAL;
                    end
                    else if (in_byte == CH_QUOTE)
                    begin
                        st_next.hex      = '0;
                        st_next.hex_stop = 1'b0;
                        st_next.mode     = MODE_HEX_FIRST;
                    end
                    else if (is_delim)
                    begin
                        st_next.letters = '0;
                        st_next.wlen    = '0;
                        st_next.mode    = MODE_NORMAL;
                    end
                    else
                    begin
                        st_next.letters = {16'h0000, low_byte};
                        st_next.wlen    = 3'd1;
                        st_next.mode    = MODE_WORD;
                    end
                end
                MODE_WORD:
                begin
                    if (is_delim)
                    begin
                        st_next.letters = '0;
                        st_next.wlen    = '0;
                        st_next.mode    = MODE_NORMAL;
                        if (in_byte != CH_SP)
                        begin
                            st_next.mode   = nb_mode;
                            st_next.gdepth = nb_g;
                            st_next.sdepth = nb_s;
                        end
                    end
                    else
                    begin
                        if (st_reg.wlen < 3'd3)
                        begin
                            st_next.letters = {st_reg.letters[15:0], low_byte};
                        end
                        if (st_reg.wlen < 3'd4)
                        begin
                            st_next.wlen = st_reg.wlen + 3'd1;
                        end
                    end
                end
                MODE_HEX_FIRST:
                begin
                    st_next.hex      = hex_upd;
                    st_next.hex_stop = stop_upd;
                    st_next.mode     = MODE_HEX_SECOND;
                end
                MODE_HEX_SECOND:
                begin
                    st_next.hex      = '0;
                    st_next.hex_stop = 1'b0;
                    st_next.mode     = MODE_NORMAL;
                end
                MODE_SKIP:
                begin
                    if (in_byte == CH_BSL)
                    begin
                        st_next.mode = MODE_SKIP_ESC;
                    end
                    else if (in_byte == CH_LBR)
                    begin
                        if (st_reg.sdepth < DEPTH_MAX)
                        begin
                            st_next.sdepth = st_reg.sdepth + DEPTH_ONE;
                        end
                    end
                    else if (in_byte == CH_RBR)
                    begin
                        st_next.sdepth = skip_dec;
                        if (skip_dec == '0)
                        begin
                            st_next.mode = MODE_NORMAL;
                        end
                    end
                end
                MODE_SKIP_ESC:
                begin
                    st_next.mode = MODE_SKIP;
                end
                default:
                begin
                    st_next.mode   = nb_mode;
                    st_next.gdepth = nb_g;
                    st_next.sdepth = nb_s;
                end
            endcase
        end
    end

    // result items
    always_comb
    begin
        res = '0;
        if (eot)
        begin
            if (st_reg.mode == MODE_WORD && word_tab)
            begin
                res.item[0] = mk(CH_TAB, 1'b1, 1'b0);
                res.item[1] = mk(8'h00, 1'b0, 1'b1);
                res.cnt     = RES_CNT_W'(2);
            end
            else if (st_reg.mode == MODE_WORD && word_par)
            begin
                res.item[0] = mk(CH_CR, 1'b1, 1'b0);
                res.item[1] = mk(CH_LF, 1'b1, 1'b0);
                res.item[2] = mk(8'h00, 1'b0, 1'b1);
                res.cnt     = RES_CNT_W'(3);
            end
            else if (st_reg.mode == MODE_HEX_FIRST || st_reg.mode == MODE_HEX_SECOND)
            begin
                res.item[0] = mk(st_reg.hex, 1'b1, 1'b0);
                res.item[1] = mk(8'h00, 1'b0, 1'b1);
                res.cnt     = RES_CNT_W'(2);
            end
            else
            begin
                res.item[0] = mk(8'h00, 1'b0, 1'b1);
                res.cnt     = RES_CNT_W'(1);
            end
        end
        else
        begin
            case (st_reg.mode)
                MODE_ESC:
                begin
                    if (in_byte inside {CH_BSL, CH_LBR, CH_RBR})
                    begin
                        res.item[0] = mk(in_byte, 1'b1, 1'b0);
                        res.cnt     = RES_CNT_W'(1);
                    end
                end
                MODE_WORD:
                begin
                    if (is_delim && word_tab)
                    begin
                        res.item[0] = mk(CH_TAB, 1'b1, 1'b0);
                        res.cnt     = RES_CNT_W'(1);
                    end
                    else if (is_delim && word_par)
                    begin
                        res.item[0] = mk(CH_CR, 1'b1, 1'b0);
                        res.item[1] = mk(CH_LF, 1'b1, 1'b0);
                        res.cnt     = RES_CNT_W'(2);
                    end
                end
                MODE_HEX_SECOND:
                begin
                    res.item[0] = mk(hex_upd, 1'b1, 1'b0);
                    res.cnt     = RES_CNT_W'(1);
                end
                MODE_HEX_FIRST, MODE_SKIP, MODE_SKIP_ESC:
                begin
                    res.cnt = '0;
                end
                default:
                begin
                    if (!(in_byte inside {CH_CR, CH_LF, CH_LBR, CH_RBR, CH_BSL}))
                    begin
                        res.item[0] = mk(in_byte, 1'b1, 1'b0);
                        res.cnt     = RES_CNT_W'(1);
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= ST_RESET;
        end
        else if (step)
        begin
            st_reg <= st_next;
        end
    end

endmodule

// ===== src/rtf_res_fifo.sv =====
module rtf_res_fifo
    import rtf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  res_t               res,
    output fifo_stat_t         stat,
    rtf_out_if.source          out_ch
);

    item_t                  mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]  wr_ptr_reg;
    logic [FIFO_PTR_W-1:0]  wr_ptr_next;
    logic [FIFO_PTR_W-1:0]  rd_ptr_reg;
    logic [FIFO_PTR_W-1:0]  rd_ptr_next;
    logic [FIFO_CNT_W-1:0]  cnt_reg;
    logic [FIFO_CNT_W-1:0]  cnt_next;
    logic [FIFO_CNT_W-1:0]  push_cnt;
    logic                   pop;
    item_t                  head;

    assign head            = mem_reg[rd_ptr_reg];
    assign out_ch.valid    = (cnt_reg != '0);
    assign out_ch.out_byte = head.out_byte;
    assign out_ch.has_byte = head.has_byte;
    assign out_ch.last     = head.last;
    assign pop             = out_ch.valid & out_ch.ready;
    assign push_cnt        = push ? FIFO_CNT_W'(res.cnt) : '0;
    assign stat.fill       = cnt_reg;

    assign wr_ptr_next = wr_ptr_reg + FIFO_PTR_W'(push_cnt);
    assign rd_ptr_next = rd_ptr_reg + FIFO_PTR_W'(pop);
    assign cnt_next    = cnt_reg + push_cnt - FIFO_CNT_W'(pop);

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_RES; i++)
        begin
            if (FIFO_CNT_W'(i) < push_cnt)
            begin
                mem_reg[wr_ptr_reg + FIFO_PTR_W'(i)] <= res.item[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// ===== src/rtf_plain_text_extractor_core.sv =====
// Path: an accepted input item waits in the input register until the result queue
// has room for its results, which are then written into the queue and offered.
// Throughput: one input item per cycle while each item yields at most one result
// and the receiver is ready; an item that yields two or three results holds the
// input until the single-item-per-cycle drain of the 4-entry result queue has room.
// Reset (rst_n, async, active low) returns the parser to plain text with zero depth
// and empties the input register and result queue.
module rtf_plain_text_extractor_core
    import rtf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    rtf_in_if.sink     in_ch,
    rtf_out_if.source  out_ch
);

    logic       in_vld_reg;
    logic       in_vld_next;
    logic [7:0] in_byte_reg;
    logic       in_eot_reg;
    logic       in_take;
    logic       adv;
    res_t       res;
    fifo_stat_t fifo_stat;

    // queue must hold the worst case of one item before it is parsed
    assign adv          = in_vld_reg && (fifo_stat.fill <= FIFO_CNT_W'(FIFO_DEPTH - MAX_RES));
    assign in_ch.ready  = ~in_vld_reg | adv;
    assign in_take      = in_ch.valid & in_ch.ready;
    assign in_vld_next  = in_take ? 1'b1 : (adv ? 1'b0 : in_vld_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg <= in_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_byte_reg <= in_ch.in_byte;
            in_eot_reg  <= in_ch.end_of_text;
        end
    end

    rtf_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (adv),
        .in_byte (in_byte_reg),
        .eot     (in_eot_reg),
        .res     (res)
    );

    rtf_res_fifo u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (adv),
        .res    (res),
        .stat   (fifo_stat),
        .out_ch (out_ch)
    );

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_stat.fill <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("result queue overflow");

    a_eot_marker: assert property (@(posedge clk) disable iff (!rst_n)
        adv && in_eot_reg |-> (res.cnt != '0) && res.item[res.cnt - RES_CNT_W'(1)].last
            && !res.item[res.cnt - RES_CNT_W'(1)].has_byte)
        else $error("end of text without final marker");

    a_no_stray_last: assert property (@(posedge clk) disable iff (!rst_n)
        adv && !in_eot_reg |-> !res.item[0].last && !res.item[1].last && !res.item[2].last)
        else $error("last flag on ordinary item");
`endif

endmodule

// ===== verif/testbench.sv =====
module testbench;
    import rtf_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int MAX_REPORTS = 40;
    localparam int NEST_RUN    = 12;

    logic clk;
    logic rst_n;

    rtf_in_if  in_ch();
    rtf_out_if out_ch();

    rtf_plain_text_extractor_core u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // idling odds in percent, changed between phases
    int send_gap_pct;
    int stall_pct;
    bit hold_request;
    int bytes_sent;
    int errors;

    // parser shadow state
    mode_t       pmode;
    int          grp_depth;
    int          skip_level;
    logic [23:0] letters;
    int          letter_cnt;
    logic [7:0]  hex_acc;
    logic        hex_done;

    item_t plain_text_q[$];

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic void emit(logic [7:0] b, logic has, logic fin);
        item_t r;
        r.out_byte = b;
        r.has_byte = has;
        r.last     = fin;
        plain_text_q.push_back(r);
    endfunction

    function automatic void clear_parser();
        pmode      = MODE_NORMAL;
        grp_depth  = 0;
        skip_level = 0;
        letters    = '0;
        letter_cnt = 0;
        hex_acc    = '0;
        hex_done   = 1'b0;
    endfunction

    function automatic int hex_val(logic [7:0] b);
        if (b inside {[8'h30:8'h39]})
            return int'(b) - 'h30;
        if (b inside {[8'h61:8'h66]})
            return int'(b) - 'h61 + 10;
        if (b inside {[8'h41:8'h46]})
            return int'(b) - 'h41 + 10;
        return -1;
    endfunction

    function automatic void end_word();
        if (letter_cnt == 3)
        begin
            if (letters == WORD_TAB)
                emit(CH_TAB, 1'b1, 1'b0);
            else if (letters == WORD_PAR)
            begin
                emit(CH_CR, 1'b1, 1'b0);
                emit(CH_LF, 1'b1, 1'b0);
            end
        end
        letters    = '0;
        letter_cnt = 0;
    endfunction

    function automatic void plain_byte(logic [7:0] b);
        case (b)
            CH_CR, CH_LF: ;
            CH_LBR:
            begin
                // only the outermost group is kept, anything below is skipped
                if (grp_depth >= 1)
                begin
                    skip_level = 1;
                    pmode      = MODE_SKIP;
                end
                else if (grp_depth < MAX_NEST)
                    grp_depth++;
            end
            CH_RBR:
            begin
                if (grp_depth > 0)
                    grp_depth--;
            end
            CH_BSL:
                pmode = MODE_ESC;
            default:
                emit(b, 1'b1, 1'b0);
        endcase
    endfunction

    function automatic void word_byte(logic [7:0] b);
        logic [7:0] c;
        c = b;
        if (c == CH_BSL || c == CH_LBR || c == CH_RBR || c == CH_CR || c == CH_LF || c == CH_SP)
        begin
            end_word();
            pmode = MODE_NORMAL;
            // a space delimiter is swallowed
            if (c != CH_SP)
                plain_byte(c);
        end
        else
        begin
            if (c inside {[8'h41:8'h5A]})
                c = c + 8'd32;
            if (letter_cnt < 3)
                letters = {letters[15:0], c};
            if (letter_cnt < 4)
                letter_cnt++;
        end
    endfunction

    function automatic void hex_byte(logic [7:0] b);
        int d;
        d = hex_val(b);
        if (!hex_done && d >= 0)
            hex_acc = {hex_acc[3:0], 4'(d)};
        else
            hex_done = 1'b1;
    endfunction

    function automatic void predict_item(logic [7:0] b, logic eot);
        if (eot)
        begin
            if (pmode == MODE_WORD)
                end_word();
            else if (pmode == MODE_HEX_FIRST || pmode == MODE_HEX_SECOND)
                emit(hex_acc, 1'b1, 1'b0);
            emit(8'h00, 1'b0, 1'b1);
            clear_parser();
        end
        else
        begin
            case (pmode)
                MODE_ESC:
                begin
                    if (b == CH_BSL || b == CH_LBR || b == CH_RBR)
                    begin
                        emit(b, 1'b1, 1'b0);
                        pmode = MODE_NORMAL;
                    end
                    else if (b == CH_QUOTE)
                    begin
                        hex_acc  = '0;
                        hex_done = 1'b0;
                        pmode    = MODE_HEX_FIRST;
                    end
                    else
                    begin
                        letters    = '0;
                        letter_cnt = 0;
                        pmode      = MODE_WORD;
                        word_byte(b);
                    end
                end
                MODE_WORD:
                    word_byte(b);
                MODE_HEX_FIRST:
                begin
                    hex_byte(b);
                    pmode = MODE_HEX_SECOND;
                end
                MODE_HEX_SECOND:
                begin
                    hex_byte(b);
                    emit(hex_acc, 1'b1, 1'b0);
                    hex_acc  = '0;
                    hex_done = 1'b0;
                    pmode    = MODE_NORMAL;
                end
                MODE_SKIP:
                begin
                    if (b == CH_BSL)
                        pmode = MODE_SKIP_ESC;
                    else if (b == CH_LBR)
                    begin
                        if (skip_level < MAX_NEST)
                            skip_level++;
                    end
                    else if (b == CH_RBR)
                    begin
                        if (skip_level > 0)
                            skip_level--;
                        if (skip_level == 0)
                            pmode = MODE_NORMAL;
                    end
                end
                MODE_SKIP_ESC:
                    pmode = MODE_SKIP;
                default:
                begin
                    pmode = MODE_NORMAL;
                    plain_byte(b);
                end
            endcase
        end
    endfunction

    task automatic check_result();
        item_t got;
        item_t want;
        got.out_byte = out_ch.out_byte;
        got.has_byte = out_ch.has_byte;
        got.last     = out_ch.last;
        if (plain_text_q.size() == 0)
        begin
            errors++;
            if (errors < MAX_REPORTS)
                $display("%0t: unexpected item out_byte %h has_byte %b last %b",
                         $time, got.out_byte, got.has_byte, got.last);
        end
        else
        begin
            want = plain_text_q.pop_front();
            if (got.out_byte !== want.out_byte)
            begin
                errors++;
                if (errors < MAX_REPORTS)
                    $display("%0t: out_byte expected %h got %h",
                             $time, want.out_byte, got.out_byte);
            end
            if (got.has_byte !== want.has_byte)
            begin
                errors++;
                if (errors < MAX_REPORTS)
                    $display("%0t: has_byte expected %b got %b",
                             $time, want.has_byte, got.has_byte);
            end
            if (got.last !== want.last)
            begin
                errors++;
                if (errors < MAX_REPORTS)
                    $display("%0t: last expected %b got %b", $time, want.last, got.last);
            end
        end
    endtask

    // results first: nothing accepted at this edge can come out at the same edge
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
            check_result();
        if (rst_n && in_ch.valid && in_ch.ready)
            predict_item(in_ch.in_byte, in_ch.end_of_text);
    end

    // receiver: random stalls, plus one long hold-off on request
    initial
    begin
        int hold_left;
        hold_left    = 0;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                out_ch.ready = 1'b0;
                hold_left--;
            end
            else
                out_ch.ready = ($urandom_range(99) >= stall_pct);
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("testbench failed");
        $finish;
    end

    // valid stays high after acceptance; the next call moves it at the next falling edge
    task automatic send_item(logic [7:0] b, logic eot);
        @(negedge clk);
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_ch.valid   = 1'b0;
            in_ch.in_byte = 8'($urandom_range(255));
            @(negedge clk);
        end
        in_ch.valid       = 1'b1;
        in_ch.in_byte     = b;
        in_ch.end_of_text = eot;
        do
            @(posedge clk);
        while (!in_ch.ready);
        bytes_sent++;
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
            send_item(s[i], 1'b0);
    endtask

    task automatic send_end_of_text();
        send_item(8'($urandom_range(255)), 1'b1);
    endtask

    function automatic logic [7:0] mixed_case(logic [7:0] c);
        return $urandom_range(1) ? c - 8'd32 : c;
    endfunction

    function automatic logic [7:0] hex_char();
        string digits;
        digits = "0123456789abcdefABCDEF";
        return digits[$urandom_range(21)];
    endfunction

    task automatic send_fragment();
        int    pick;
        int    n;
        string w;
        pick = $urandom_range(99);
        if (pick < 30)
            send_item(8'($urandom_range(32, 122)), 1'b0);
        else if (pick < 38)
        begin
            send_item(CH_BSL, 1'b0);
            case ($urandom_range(2))
                0:       send_item(CH_BSL, 1'b0);
                1:       send_item(CH_LBR, 1'b0);
                default: send_item(CH_RBR, 1'b0);
            endcase
        end
        else if (pick < 52)
        begin
            send_item(CH_BSL, 1'b0);
            send_item(CH_QUOTE, 1'b0);
            repeat (2)
                send_item(($urandom_range(99) < 85) ? hex_char() : 8'($urandom_range(255)),
                          1'b0);
        end
        else if (pick < 72)
        begin
            send_item(CH_BSL, 1'b0);
            if ($urandom_range(1))
                w = $urandom_range(1) ? "tab" : "par";
            else
            begin
                w = "";
                n = $urandom_range(1, 5);
                repeat (n)
                    w = {w, string'(8'($urandom_range(97, 122)))};
            end
            for (int i = 0; i < w.len(); i++)
                send_item(mixed_case(w[i]), 1'b0);
            case ($urandom_range(6))
                0, 1, 2: send_item(CH_SP, 1'b0);
                3:       send_item(CH_CR, 1'b0);
                4:       send_item(CH_LF, 1'b0);
                5:       send_item(CH_LBR, 1'b0);
                default: send_item(CH_RBR, 1'b0);
            endcase
        end
        else if (pick < 80)
        begin
            send_item(CH_LBR, 1'b0);
            n = $urandom_range(6);
            repeat (n)
            begin
                case ($urandom_range(2))
                    0:
                        send_item(8'($urandom_range(97, 122)), 1'b0);
                    1:
                    begin
                        send_item(CH_BSL, 1'b0);
                        send_item(8'($urandom_range(255)), 1'b0);
                    end
                    default:
                        send_text("{q}");
                endcase
            end
            send_item(CH_RBR, 1'b0);
        end
        else if (pick < 85)
            send_item($urandom_range(1) ? CH_CR : CH_LF, 1'b0);
        else if (pick < 90)
            send_item($urandom_range(1) ? CH_LBR : CH_RBR, 1'b0);
        else if (pick < 96)
            send_item(8'($urandom_range(255)), 1'b0);
        else
            send_end_of_text();
    endtask

    task automatic test_plain_text();
        send_text("{A");
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(CH_CR, 1'b0);
        send_item(CH_LF, 1'b0);
        send_text("}}");
        send_end_of_text();
    endtask

    task automatic test_escapes();
        // literals, full hex, hex cut short by a non-digit, hex cut by end of text
        send_text("\\\\\\{\\}\\'Ff\\'Fz\\'A");
        send_end_of_text();
    endtask

    task automatic test_control_words();
        send_text("\\TaB \\par}\\PAR");
        send_end_of_text();
        send_text("\\");
        send_end_of_text();
    endtask

    task automatic test_skipped_groups();
        // escaped brace inside a skipped group, then a group left open at the end
        send_text("{{\\}{d}}e{x");
        send_end_of_text();
    endtask

    task automatic test_deep_nesting();
        send_text("{a");
        repeat (NEST_RUN)
            send_item(CH_LBR, 1'b0);
        repeat (NEST_RUN - 2)
            send_item(CH_RBR, 1'b0);
        send_text("}}z");
        send_end_of_text();
    endtask

    task automatic test_random_text(int n);
        int start;
        start = bytes_sent;
        while (bytes_sent - start < n)
            send_fragment();
    endtask

    task automatic test_output_backpressure();
        hold_request = 1'b1;
        repeat (12)
        begin
            send_text("\\par ");
            send_item(8'($urandom_range(97, 122)), 1'b0);
        end
    endtask

    initial
    begin
        rst_n             = 1'b0;
        in_ch.valid       = 1'b0;
        in_ch.in_byte     = 8'h00;
        in_ch.end_of_text = 1'b0;
        hold_request      = 1'b0;
        bytes_sent        = 0;
        errors            = 0;
        send_gap_pct      = 7;
        stall_pct         = 49;
        clear_parser();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_plain_text();
        test_escapes();
        test_control_words();
        test_skipped_groups();
        test_deep_nesting();
        test_random_text(40);

        send_gap_pct = 49;
        stall_pct    = 7;
        test_random_text(40);

        send_gap_pct = 0;
        stall_pct    = 0;
        test_output_backpressure();
        test_random_text(40);
        send_end_of_text();

        @(negedge clk);
        in_ch.valid = 1'b0;
        while (plain_text_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
